### rtl/local_alignment_scorer_macros.svh
// Assertion helpers for the RTL of the alignment scorer; las_engine includes them.
`ifndef LOCAL_ALIGNMENT_SCORER_MACROS_SVH
`define LOCAL_ALIGNMENT_SCORER_MACROS_SVH
`ifndef SYNTHESIS
`define LAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define LAS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define LAS_ASSERT(lbl, prop)
`define LAS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/las_pkg.sv
package las_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned ScoreW = 10;
  localparam int unsigned SumW = ScoreW + 2;
  localparam int unsigned OutCoordW = 7;
  localparam int unsigned CharW = 8;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned ScoreCap = 1023;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAppendX = 2'd1;
  localparam logic [1:0] CmdAppendY = 2'd2;
  localparam logic [1:0] CmdFetch = 2'd3;

  localparam logic [1:0] CfgMatch = 2'd0;
  localparam logic [1:0] CfgMismatch = 2'd1;
  localparam logic [1:0] CfgDelete = 2'd2;
  localparam logic [1:0] CfgInsert = 2'd3;

  localparam logic [1:0] PtrN = 2'd0;
  localparam logic [1:0] PtrW = 2'd1;
  localparam logic [1:0] PtrNW = 2'd2;
  localparam logic [1:0] PtrZ = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND_X,
    OP_APPEND_Y,
    OP_FETCH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
  } req_t;

  typedef struct packed {
    logic [3:0]        match_score;
    logic signed [4:0] mismatch_score;
    logic signed [4:0] delete_gap_score;
    logic signed [4:0] insert_gap_score;
  } cfg_t;

  typedef struct packed {
    logic [ScoreW-1:0]    best_score;
    logic [OutCoordW-1:0] end_x;
    logic [OutCoordW-1:0] end_y;
    logic [CharW-1:0]     x_char;
    logic [CharW-1:0]     y_char;
    logic                 pair_valid;
    logic                 last_of_alignment;
    logic                 last_overall;
    logic                 exhausted;
    logic                 truncated;
  } res_t;

endpackage

### rtl/local_alignment_scorer.sv
// Channel     | Handshake             | Payload
// ------------+-----------------------+---------------------------------------------
// request in  | push / full           | cmd_i, char_in_i
// result out  | pop / empty           | best_score_o .. truncated_o
// config      | cfg_we_i              | cfg_index_i, cfg_data_i
//
// Clear and append requests take one cycle each once they reach the engine.
// The first fetch after loading fills the matrix, scans it for the maximum and
// traces back from it; each cell and each step is first read from the score
// memory, which has a single read port, and then evaluated. Each fetch yields one
// result. Reset is asynchronous; no memory is cleared, so the block is ready at
// once. Two-entry queues on both sides let requests and results stall independently.
module local_alignment_scorer #(
  parameter int unsigned MAX_LEN = las_pkg::MaxLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    cmd_i,
  input  logic [las_pkg::CharW-1:0]     char_in_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [las_pkg::ScoreW-1:0]    best_score_o,
  output logic [las_pkg::OutCoordW-1:0] end_x_o,
  output logic [las_pkg::OutCoordW-1:0] end_y_o,
  output logic [las_pkg::CharW-1:0]     x_char_o,
  output logic [las_pkg::CharW-1:0]     y_char_o,
  output logic                          pair_valid_o,
  output logic                          last_of_alignment_o,
  output logic                          last_overall_o,
  output logic                          exhausted_o,
  output logic                          truncated_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [las_pkg::CfgDataW-1:0]  cfg_data_i
);
  import las_pkg::*;

  cfg_t cfg_q;
  req_t req;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] res_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score      <= 4'd1;
      cfg_q.mismatch_score   <= -5'sd1;
      cfg_q.delete_gap_score <= -5'sd1;
      cfg_q.insert_gap_score <= -5'sd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMatch:    cfg_q.match_score      <= cfg_data_i[3:0];
        CfgMismatch: cfg_q.mismatch_score   <= cfg_data_i;
        CfgDelete:   cfg_q.delete_gap_score <= cfg_data_i;
        default:     cfg_q.insert_gap_score <= cfg_data_i;
      endcase
    end
  end

  las_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_i),
    .char_i (char_in_i),
    .full_o (full),
    .pop_i  (cmd_pop),
    .req_o  (req),
    .empty_o(cmd_empty)
  );

  las_engine #(
    .MAX_LEN(MAX_LEN)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_i      (req),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  las_fifo #(
    .W($bits(res_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_raw),
    .empty_o(empty)
  );

  assign res_out             = res_t'(res_raw);
  assign best_score_o        = res_out.best_score;
  assign end_x_o             = res_out.end_x;
  assign end_y_o             = res_out.end_y;
  assign x_char_o            = res_out.x_char;
  assign y_char_o            = res_out.y_char;
  assign pair_valid_o        = res_out.pair_valid;
  assign last_of_alignment_o = res_out.last_of_alignment;
  assign last_overall_o      = res_out.last_overall;
  assign exhausted_o         = res_out.exhausted;
  assign truncated_o         = res_out.truncated;

endmodule

### rtl/las_fifo.sv
module las_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   cnt_q;
  logic         do_push;
  logic         do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/las_front.sv
module las_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [1:0]                 cmd_i,
  input  logic [las_pkg::CharW-1:0]  char_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output las_pkg::req_t              req_o,
  output logic                       empty_o
);
  import las_pkg::*;

  req_t req_in;
  logic [$bits(req_t)-1:0] req_raw;

  // The character only matters for appends; other requests carry zero.
  always_comb begin
    req_in.ch = '0;
    unique case (cmd_i)
      CmdClear:   req_in.op = OP_CLEAR;
      CmdAppendX: begin
        req_in.op = OP_APPEND_X;
        req_in.ch = char_i;
      end
      CmdAppendY: begin
        req_in.op = OP_APPEND_Y;
        req_in.ch = char_i;
      end
      default:    req_in.op = OP_FETCH;
    endcase
  end

  las_fifo #(
    .W($bits(req_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (req_in),
    .full_o (full_o),
    .pop_i  (pop_i),
    .data_o (req_raw),
    .empty_o(empty_o)
  );

  assign req_o = req_t'(req_raw);

endmodule

### rtl/las_engine.sv
`include "local_alignment_scorer_macros.svh"

module las_engine #(
  parameter int unsigned MAX_LEN = las_pkg::MaxLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  las_pkg::cfg_t  cfg_i,
  input  las_pkg::req_t  req_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output las_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);
  import las_pkg::*;

  localparam int unsigned Stride = MAX_LEN + 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned GD = Stride * Stride;
  localparam int unsigned GW = $clog2(GD);
  localparam int unsigned EW = ScoreW + 2;
  localparam logic signed [SumW-1:0] CapS = SumW'(ScoreCap);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FILL_RD  = 4'd1;
  localparam logic [3:0] S_FILL_CMP = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_TR_RD    = 4'd5;
  localparam logic [3:0] S_TR_CMP   = 4'd6;
  localparam logic [3:0] S_SERVE    = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  function automatic logic [GW-1:0] cell_addr(input logic [CW-1:0] i, input logic [CW-1:0] j);
    cell_addr = GW'(i) * GW'(Stride) + GW'(j);
  endfunction

  logic [3:0]        state_q;
  logic [CW-1:0]     x_cnt_q, y_cnt_q;
  logic              ovf_q;
  logic [CW-1:0]     i_q, j_q;
  logic [CW-1:0]     cur_i_q, cur_j_q, nxt_i_q, nxt_j_q;
  logic              has_next_q, finished_q, look_q;
  logic [CW-1:0]     pcnt_q, rcur_q;
  logic [ScoreW-1:0] up_q, diag_q, best_q;

  logic [CharW-1:0]   x_mem [MAX_LEN];
  logic [CharW-1:0]   y_mem [MAX_LEN];
  logic [EW-1:0]      grid_mem [GD];
  logic [2*CharW-1:0] stack_mem [MAX_LEN];
  logic [CharW-1:0]   x_rd_q, y_rd_q;
  logic [EW-1:0]      g_rd_q;
  logic [2*CharW-1:0] s_rd_q;

  logic [AW-1:0] x_ra, y_ra, s_ra;
  logic [GW-1:0] g_ra, g_wa;
  logic          x_we, y_we, g_we, s_we;
  logic          cmd_take;

  logic [ScoreW-1:0]      left;
  logic signed [SumW-1:0] sub, dg, upv, lf, m;
  logic [1:0]             p;
  logic [ScoreW-1:0]      mcap;
  logic                   scan_hit;
  logic [ScoreW-1:0]      g_score;
  logic [1:0]             g_ptr;
  logic [CW-1:0]          rc_next;
  logic                   last_al;

  assign g_score = g_rd_q[ScoreW-1:0];
  assign g_ptr   = g_rd_q[EW-1:ScoreW];

  assign x_ra = AW'(i_q - CW'(1));
  assign y_ra = AW'(j_q - CW'(1));
  assign s_ra = AW'(pcnt_q - rcur_q - CW'(1));
  assign g_ra = (state_q == S_FILL_RD) ? cell_addr(i_q, j_q - CW'(1)) : cell_addr(i_q, j_q);
  assign g_wa = cell_addr(i_q, j_q);

  assign cmd_take = (state_q == S_IDLE || state_q == S_SERVE) && !cmd_empty_i
                    && (req_i.op != OP_FETCH);
  assign cmd_pop_o = cmd_take || (state_q == S_EMIT && !res_full_i);
  assign res_push_o = (state_q == S_EMIT) && !res_full_i;

  assign x_we = cmd_take && (req_i.op == OP_APPEND_X) && (x_cnt_q < CW'(MAX_LEN));
  assign y_we = cmd_take && (req_i.op == OP_APPEND_Y) && (y_cnt_q < CW'(MAX_LEN));
  assign g_we = (state_q == S_FILL_CMP);
  assign s_we = (state_q == S_TR_CMP) && (g_score != '0) && (g_ptr == PtrNW)
                && (pcnt_q < CW'(MAX_LEN));

  // One cell of the recurrence: the cell above comes from the previous step,
  // the left cell from memory, and the diagonal is the previous left value.
  always_comb begin
    left = (j_q == CW'(1)) ? '0 : g_score;
    if (x_rd_q == y_rd_q) begin
      sub = SumW'(cfg_i.match_score);
    end else begin
      sub = SumW'(cfg_i.mismatch_score);
    end
    dg  = $signed(SumW'(diag_q)) + sub;
    upv = $signed(SumW'(up_q)) + SumW'(cfg_i.delete_gap_score);
    lf  = $signed(SumW'(left)) + SumW'(cfg_i.insert_gap_score);
    m = '0;
    if (dg > m) m = dg;
    if (upv > m) m = upv;
    if (lf > m) m = lf;
    priority if (m == upv) p = PtrN;
    else if (m == lf) p = PtrW;
    else if (m == dg) p = PtrNW;
    else p = PtrZ;
    mcap = (m > CapS) ? ScoreW'(ScoreCap) : m[ScoreW-1:0];
  end

  assign scan_hit = (i_q == '0 || j_q == '0) ? (best_q == '0) : (g_score == best_q);
  assign rc_next  = rcur_q + CW'(1);
  assign last_al  = !finished_q && ((pcnt_q == '0) || (rc_next >= pcnt_q));

  always_comb begin
    res_o = '0;
    res_o.best_score = best_q;
    res_o.truncated  = ovf_q;
    if (finished_q) begin
      res_o.exhausted = 1'b1;
    end else begin
      res_o.end_x = OutCoordW'(cur_i_q);
      res_o.end_y = OutCoordW'(cur_j_q);
      if (pcnt_q != '0) begin
        res_o.x_char     = s_rd_q[2*CharW-1:CharW];
        res_o.y_char     = s_rd_q[CharW-1:0];
        res_o.pair_valid = 1'b1;
      end
      res_o.last_of_alignment = last_al;
      res_o.last_overall      = last_al && !has_next_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[AW'(x_cnt_q)] <= req_i.ch;
    if (y_we) y_mem[AW'(y_cnt_q)] <= req_i.ch;
    if (g_we) grid_mem[g_wa] <= {p, mcap};
    if (s_we) stack_mem[AW'(pcnt_q)] <= {x_rd_q, y_rd_q};
    x_rd_q <= x_mem[x_ra];
    y_rd_q <= y_mem[y_ra];
    g_rd_q <= grid_mem[g_ra];
    s_rd_q <= stack_mem[s_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      x_cnt_q    <= '0;
      y_cnt_q    <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      cur_i_q    <= '0;
      cur_j_q    <= '0;
      nxt_i_q    <= '0;
      nxt_j_q    <= '0;
      has_next_q <= 1'b0;
      finished_q <= 1'b0;
      look_q     <= 1'b0;
      pcnt_q     <= '0;
      rcur_q     <= '0;
      up_q       <= '0;
      diag_q     <= '0;
      best_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE, S_SERVE: begin
          if (!cmd_empty_i) begin
            unique case (req_i.op)
              OP_CLEAR: begin
                x_cnt_q <= '0;
                y_cnt_q <= '0;
                ovf_q   <= 1'b0;
                state_q <= S_IDLE;
              end
              OP_APPEND_X: begin
                if (x_we) x_cnt_q <= x_cnt_q + CW'(1);
                else ovf_q <= 1'b1;
                state_q <= S_IDLE;
              end
              OP_APPEND_Y: begin
                if (y_we) y_cnt_q <= y_cnt_q + CW'(1);
                else ovf_q <= 1'b1;
                state_q <= S_IDLE;
              end
              default: begin
                if (state_q == S_SERVE) begin
                  state_q <= S_EMIT;
                end else begin
                  best_q     <= '0;
                  finished_q <= 1'b0;
                  has_next_q <= 1'b0;
                  up_q       <= '0;
                  diag_q     <= '0;
                  look_q     <= 1'b0;
                  if (x_cnt_q == '0 || y_cnt_q == '0) begin
                    i_q     <= '0;
                    j_q     <= '0;
                    state_q <= S_SCAN_RD;
                  end else begin
                    i_q     <= CW'(1);
                    j_q     <= CW'(1);
                    state_q <= S_FILL_RD;
                  end
                end
              end
            endcase
          end
        end
        S_FILL_RD: state_q <= S_FILL_CMP;
        S_FILL_CMP: begin
          if (mcap > best_q) best_q <= mcap;
          if (i_q == x_cnt_q) begin
            up_q   <= '0;
            diag_q <= '0;
            if (j_q == y_cnt_q) begin
              i_q     <= '0;
              j_q     <= '0;
              look_q  <= 1'b0;
              state_q <= S_SCAN_RD;
            end else begin
              i_q     <= CW'(1);
              j_q     <= j_q + CW'(1);
              state_q <= S_FILL_RD;
            end
          end else begin
            up_q    <= mcap;
            diag_q  <= left;
            i_q     <= i_q + CW'(1);
            state_q <= S_FILL_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (scan_hit) begin
            if (!look_q) begin
              cur_i_q <= i_q;
              cur_j_q <= j_q;
              pcnt_q  <= '0;
              rcur_q  <= '0;
              state_q <= S_TR_RD;
            end else begin
              nxt_i_q    <= i_q;
              nxt_j_q    <= j_q;
              has_next_q <= 1'b1;
              state_q    <= S_SERVE;
            end
          end else if (j_q == y_cnt_q) begin
            if (i_q == x_cnt_q) begin
              has_next_q <= 1'b0;
              if (!look_q) finished_q <= 1'b1;
              state_q <= S_SERVE;
            end else begin
              i_q     <= i_q + CW'(1);
              j_q     <= '0;
              state_q <= S_SCAN_RD;
            end
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_TR_RD, S_TR_CMP: begin
          if ((state_q == S_TR_RD && (i_q == '0 || j_q == '0))
              || (state_q == S_TR_CMP && (g_score == '0 || g_ptr == PtrZ))) begin
            // Traceback done: look ahead for the next cell holding the maximum.
            look_q <= 1'b1;
            if (cur_j_q == y_cnt_q) begin
              if (cur_i_q == x_cnt_q) begin
                has_next_q <= 1'b0;
                state_q    <= S_SERVE;
              end else begin
                i_q     <= cur_i_q + CW'(1);
                j_q     <= '0;
                state_q <= S_SCAN_RD;
              end
            end else begin
              i_q     <= cur_i_q;
              j_q     <= cur_j_q + CW'(1);
              state_q <= S_SCAN_RD;
            end
          end else if (state_q == S_TR_RD) begin
            state_q <= S_TR_CMP;
          end else begin
            unique case (g_ptr)
              PtrNW: begin
                if (s_we) pcnt_q <= pcnt_q + CW'(1);
                i_q <= i_q - CW'(1);
                j_q <= j_q - CW'(1);
              end
              PtrN:    i_q <= i_q - CW'(1);
              PtrW:    j_q <= j_q - CW'(1);
              default: i_q <= i_q;
            endcase
            state_q <= S_TR_RD;
          end
        end
        S_EMIT: begin
          if (!res_full_i) begin
            if (finished_q || !last_al) begin
              state_q <= S_SERVE;
              if (!finished_q && pcnt_q != '0) rcur_q <= rc_next;
            end else if (has_next_q) begin
              cur_i_q <= nxt_i_q;
              cur_j_q <= nxt_j_q;
              i_q     <= nxt_i_q;
              j_q     <= nxt_j_q;
              pcnt_q  <= '0;
              rcur_q  <= '0;
              state_q <= S_TR_RD;
            end else begin
              finished_q <= 1'b1;
              state_q    <= S_SERVE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LAS_ASSERT(a_push_room, res_push_o |-> !res_full_i)
  `LAS_ASSERT(a_clear_empties, (cmd_pop_o && req_i.op == OP_CLEAR) |=> (x_cnt_q == '0 && y_cnt_q == '0))
  `LAS_ASSERT(a_stack_bound, pcnt_q <= CW'(MAX_LEN))
  `LAS_ASSERT(a_fill_range, (state_q == S_FILL_CMP) |-> (i_q != '0 && i_q <= x_cnt_q && j_q != '0 && j_q <= y_cnt_q))
  `LAS_ASSERT_ALWAYS(a_no_pop_empty, !rst_ni || !(cmd_pop_o && cmd_empty_i))

endmodule
